/* src/threefish256_block_cipher_defines.svh */
// Assertion macros for the Threefish-256 core.
// Taken in by the modules that carry concurrent checks.
`ifndef THREEFISH256_BLOCK_CIPHER_DEFINES_SVH
`define THREEFISH256_BLOCK_CIPHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define TF_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TF_ASSERT(lbl, prop)
`define TF_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* src/tf256_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Threefish-256 core.
// No dependencies.
package tf256_pkg;
    localparam int NUM_WORDS   = 4;
    localparam int NUM_ROUNDS  = 72;
    localparam int NUM_SUBKEYS = NUM_ROUNDS / 4 + 1;
    localparam int NUM_REGS    = 6;
    localparam logic [63:0] C240 = 64'h1bd11bdaa9fc1a22;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_TWEAK0 = 3'd4;
    localparam logic [2:0] REG_TWEAK1 = 3'd5;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [63:0] word_t;
    typedef logic [3:0][63:0] block_t;

    typedef struct packed {
        logic valid;
        logic op;
    } ctl_t;

    function automatic logic [5:0] rot_amt(input logic [2:0] sel, input logic lane);
        logic [11:0] pair;
        case (sel)
            3'd0: pair = {6'd16, 6'd14};
            3'd1: pair = {6'd57, 6'd52};
            3'd2: pair = {6'd40, 6'd23};
            3'd3: pair = {6'd37, 6'd5};
            3'd4: pair = {6'd33, 6'd25};
            3'd5: pair = {6'd12, 6'd46};
            3'd6: pair = {6'd22, 6'd58};
            default: pair = {6'd32, 6'd32};
        endcase
        return lane ? pair[11:6] : pair[5:0];
    endfunction

    function automatic word_t rotl64(input word_t x, input logic [5:0] r);
        return (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    function automatic word_t rotr64(input word_t x, input logic [5:0] r);
        return rotl64(x, 6'(7'd64 - {1'b0, r}));
    endfunction
endpackage

/* src/tf256_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input beats and queues them in a two-entry FIFO.
// Depends on tf256_pkg and the assertion macro header.
`include "threefish256_block_cipher_defines.svh"
module tf256_front
    import tf256_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic         s_tuser,
    output logic         q_valid,
    input  logic         q_pop,
    output logic         q_op,
    output block_t       q_data
);
    logic [256:0] mem [2];
    logic [1:0]   count_reg, count_next;
    logic         wr_ptr_reg, rd_ptr_reg;
    logic         push, pop;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_op     = mem[rd_ptr_reg][256];
    assign q_data   = block_t'(mem[rd_ptr_reg][255:0]);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= {s_tuser, s_tdata};
        end
    end

    `TF_ASSERT_NEVER(a_count_range, count_reg == 2'd3)
    `TF_ASSERT(a_pop_nonempty, (q_pop |-> q_valid || !pop))
    `TF_ASSERT(a_ptr_track, (1'b1 |=> (count_reg == 2'd0) || (count_reg == 2'd2)
        || (wr_ptr_reg != rd_ptr_reg)))
endmodule

/* src/tf256_round.sv */
`timescale 1ns / 1ps
// One registered Threefish-256 round stage, forward or inverse by the beat's op bit.
// Depends on tf256_pkg.
module tf256_round
    import tf256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  ctl_t       ctl_in,
    input  block_t     v_in,
    input  logic [2:0] enc_sel,
    input  logic [2:0] dec_sel,
    input  logic       enc_inj,
    input  logic       dec_inj,
    input  block_t     enc_key,
    input  block_t     dec_key,
    output ctl_t       ctl_out,
    output block_t     v_out
);
    ctl_t   ctl_reg;
    block_t v_reg, v_next;
    block_t a, e, d;
    word_t  y0, y1, y2, y3, x0, x1, x2, x3;

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            a[i] = v_in[i] + (enc_inj ? enc_key[i] : 64'd0);
        end
        y0 = a[0] + a[1];
        y1 = rotl64(a[1], rot_amt(enc_sel, 1'b0)) ^ y0;
        y2 = a[2] + a[3];
        y3 = rotl64(a[3], rot_amt(enc_sel, 1'b1)) ^ y2;
        e  = {y1, y2, y3, y0};

        x1 = rotr64(v_in[3] ^ v_in[0], rot_amt(dec_sel, 1'b0));
        x0 = v_in[0] - x1;
        x3 = rotr64(v_in[1] ^ v_in[2], rot_amt(dec_sel, 1'b1));
        x2 = v_in[2] - x3;
        d  = {x3, x2, x1, x0};
        for (int i = 0; i < NUM_WORDS; i++) begin
            d[i] = d[i] - (dec_inj ? dec_key[i] : 64'd0);
        end
        v_next = (ctl_in.op == OP_DECRYPT) ? d : e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign v_out   = v_reg;
endmodule

/* src/tf256_back.sv */
`timescale 1ns / 1ps
// Back end: key registers, subkey schedule and the 72-round pipeline with output stage.
// Depends on tf256_pkg, tf256_round and the assertion macro header.
`include "threefish256_block_cipher_defines.svh"
module tf256_back
    import tf256_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         q_valid,
    output logic         q_pop,
    input  logic         q_op,
    input  block_t       q_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata
);
    word_t  key_reg [NUM_WORDS];
    word_t  tweak_reg [2];
    word_t  kx [NUM_WORDS + 1];
    word_t  tx [3];
    block_t sk_reg [NUM_SUBKEYS];
    ctl_t   st_ctl [NUM_ROUNDS + 1];
    block_t st_v [NUM_ROUNDS + 1];
    ctl_t   pre_reg;
    block_t pre_v_reg;
    logic   out_valid_reg;
    block_t out_v_reg, out_v_next;
    logic   adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                key_reg[i] <= '0;
            end
            tweak_reg[0] <= '0;
            tweak_reg[1] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY0:   key_reg[0]   <= cfg_wdata;
                REG_KEY1:   key_reg[1]   <= cfg_wdata;
                REG_KEY2:   key_reg[2]   <= cfg_wdata;
                REG_KEY3:   key_reg[3]   <= cfg_wdata;
                REG_TWEAK0: tweak_reg[0] <= cfg_wdata;
                REG_TWEAK1: tweak_reg[1] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        kx[NUM_WORDS] = C240;
        for (int i = 0; i < NUM_WORDS; i++) begin
            kx[i] = key_reg[i];
            kx[NUM_WORDS] = kx[NUM_WORDS] ^ key_reg[i];
        end
        tx[0] = tweak_reg[0];
        tx[1] = tweak_reg[1];
        tx[2] = tweak_reg[0] ^ tweak_reg[1];
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NUM_SUBKEYS; s++) begin
            sk_reg[s][0] <= kx[s % 5];
            sk_reg[s][1] <= kx[(s + 1) % 5] + tx[s % 3];
            sk_reg[s][2] <= kx[(s + 2) % 5] + tx[(s + 1) % 3];
            sk_reg[s][3] <= kx[(s + 3) % 5] + 64'(s);
        end
    end

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            pre_reg.valid <= q_valid;
            pre_reg.op    <= q_op;
            out_valid_reg <= st_ctl[NUM_ROUNDS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                pre_v_reg[i] <= (q_op == OP_DECRYPT) ?
                    q_data[i] - sk_reg[NUM_SUBKEYS - 1][i] : q_data[i];
            end
            out_v_reg <= out_v_next;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            out_v_next[i] = (st_ctl[NUM_ROUNDS].op == OP_DECRYPT) ? st_v[NUM_ROUNDS][i] :
                st_v[NUM_ROUNDS][i] + sk_reg[NUM_SUBKEYS - 1][i];
        end
    end

    assign st_ctl[0] = pre_reg;
    assign st_v[0]   = pre_v_reg;

    for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
        localparam int DR = NUM_ROUNDS - 1 - k;
        tf256_round u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctl_in  (st_ctl[k]),
            .v_in    (st_v[k]),
            .enc_sel (3'(k % 8)),
            .dec_sel (3'(DR % 8)),
            .enc_inj ((k % 4) == 0),
            .dec_inj ((DR % 4) == 0),
            .enc_key (sk_reg[k / 4]),
            .dec_key (sk_reg[DR / 4]),
            .ctl_out (st_ctl[k + 1]),
            .v_out   (st_v[k + 1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_v_reg;

    `TF_ASSERT(a_hold_when_stalled, (out_valid_reg && !m_tready |=> out_valid_reg))
    `TF_ASSERT(a_no_pop_stalled, (!adv |-> !q_pop))
    `TF_ASSERT(a_pre_from_queue, (adv && q_valid |=> pre_reg.valid))
endmodule

/* src/threefish256_block_cipher.sv */
`timescale 1ns / 1ps
// Threefish-256 core: one beat per cycle while m_tready is not held low.
// A block passes the queue, a pre stage (key subtract for decrypt), 72 round stages and an output stage (key add).
// A two-entry input queue feeds the pipeline; the pipeline stalls as a whole on m_tready.
// Synchronous active-low reset clears key and tweak registers to zero and empties the core.
// Depends on tf256_pkg, tf256_front and tf256_back.
module threefish256_block_cipher
    import tf256_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // in_word_0, in_word_1, in_word_2, in_word_3
    input  logic         s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // out_word_0, out_word_1, out_word_2, out_word_3
);
    logic   q_valid, q_pop, q_op;
    block_t q_data;

    tf256_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op),
        .q_data   (q_data)
    );

    tf256_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (q_op),
        .q_data    (q_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule

/* bench/threefish256_checker.sv */
`timescale 1ns / 1ps
// Checker for the Threefish-256 core: snoops the config port and both streams,
// predicts each output block and compares it with the oldest pending one.
// Depends on tf256_pkg for word and block types and constants.
module threefish256_checker
    import tf256_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [255:0] m_tdata,
    output int           fail_count,
    output int           pending_count,
    output int           blocks_checked
);
    localparam int ROT_A [8] = '{14, 52, 23, 5, 25, 46, 58, 32};
    localparam int ROT_B [8] = '{16, 57, 40, 37, 33, 12, 22, 32};

    word_t  key_copy [4];
    word_t  tweak_copy [2];
    block_t expected_blocks [$];

    function automatic word_t rol(word_t x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic word_t ror(word_t x, int r);
        return (x >> r) | (x << (64 - r));
    endfunction

    function automatic block_t cipher_block(block_t blk, logic op);
        word_t kx [5];
        word_t tx [3];
        word_t sk [19][4];
        word_t v [4];
        word_t f [4];
        kx[4] = C240;
        for (int i = 0; i < 4; i++) begin
            kx[i] = key_copy[i];
            kx[4] ^= key_copy[i];
        end
        tx[0] = tweak_copy[0];
        tx[1] = tweak_copy[1];
        tx[2] = tweak_copy[0] ^ tweak_copy[1];
        for (int s = 0; s < 19; s++) begin
            for (int i = 0; i < 4; i++) sk[s][i] = kx[(s + i) % 5];
            sk[s][1] += tx[s % 3];
            sk[s][2] += tx[(s + 1) % 3];
            sk[s][3] += word_t'(s);
        end
        for (int i = 0; i < 4; i++) v[i] = blk[i];
        if (op == OP_ENCRYPT) begin
            for (int d = 0; d < 72; d++) begin
                if (d % 4 == 0)
                    for (int i = 0; i < 4; i++) v[i] += sk[d / 4][i];
                f[0] = v[0] + v[1];
                f[1] = rol(v[1], ROT_A[d % 8]) ^ f[0];
                f[2] = v[2] + v[3];
                f[3] = rol(v[3], ROT_B[d % 8]) ^ f[2];
                v[0] = f[0]; v[1] = f[3]; v[2] = f[2]; v[3] = f[1];
            end
            for (int i = 0; i < 4; i++) v[i] += sk[18][i];
        end else begin
            for (int i = 0; i < 4; i++) v[i] -= sk[18][i];
            for (int d = 71; d >= 0; d--) begin
                f[0] = v[0]; f[3] = v[1]; f[2] = v[2]; f[1] = v[3];
                v[1] = ror(f[1] ^ f[0], ROT_A[d % 8]);
                v[0] = f[0] - v[1];
                v[3] = ror(f[3] ^ f[2], ROT_B[d % 8]);
                v[2] = f[2] - v[3];
                if (d % 4 == 0)
                    for (int i = 0; i < 4; i++) v[i] -= sk[d / 4][i];
            end
        end
        for (int i = 0; i < 4; i++) blk[i] = v[i];
        return blk;
    endfunction

    assign pending_count = expected_blocks.size();

    always @(posedge aclk) begin
        block_t want;
        block_t got;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_copy[i] = '0;
            tweak_copy[0] = '0;
            tweak_copy[1] = '0;
            expected_blocks.delete();
            fail_count = 0;
            blocks_checked = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_blocks.push_back(cipher_block(block_t'(s_tdata), s_tuser));
            if (m_tvalid && m_tready) begin
                got = block_t'(m_tdata);
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected output beat %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    blocks_checked++;
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want[i]) begin
                            $display("%0t: out_word_%0d expected %h actual %h",
                                     $time, i, want[i], got[i]);
                            fail_count++;
                        end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index <= REG_KEY3)
                    key_copy[cfg_index[1:0]] = cfg_wdata;
                else if (cfg_index == REG_TWEAK0)
                    tweak_copy[0] = cfg_wdata;
                else if (cfg_index == REG_TWEAK1)
                    tweak_copy[1] = cfg_wdata;
            end
        end
    end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Top of the Threefish-256 bench: clock, reset, key/tweak phases and block stimulus.
// Depends on tf256_pkg, threefish256_block_cipher and threefish256_checker.
module testbench;
    import tf256_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_PHASES = 6;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = REG_KEY0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         s_tuser = OP_ENCRYPT;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;
    logic         quiet = 1'b0;
    int           fail_count, pending_count, blocks_checked;
    int           cycle_count = 0;
    int           blocks_sent = 0;

    threefish256_block_cipher uut (.*);
    threefish256_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // output stall bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n - 1) @(posedge aclk);
        end
    end

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic put_block(logic op, word_t w0, word_t w1, word_t w2, word_t w3);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {w3, w2, w1, w0};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        blocks_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, word_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        word_t fill;
        word_t sample;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key and tweak, then extremes and both directions
        for (int op = 0; op < 2; op++) begin
            put_block(op[0], '0, '0, '0, '0);
            put_block(op[0], '1, '1, '1, '1);
            put_block(op[0], 64'h1, 64'h8000000000000000, '0, '1);
            put_block(op[0], 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                      64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
        end
        for (int i = 0; i < 4; i++) begin
            sample = rand_word();
            put_block(OP_ENCRYPT, sample, ~sample, sample, ~sample);
            put_block(OP_DECRYPT, ~sample, sample, ~sample, sample);
        end

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            settle();
            fill = (ph == 1) ? '1 : '0;
            write_reg(REG_KEY0, ph > 2 ? rand_word() : fill);
            write_reg(REG_KEY1, ph > 2 ? rand_word() : fill);
            write_reg(REG_KEY2, ph > 2 ? rand_word() : fill);
            write_reg(REG_KEY3, ph > 2 ? rand_word() : fill);
            write_reg(REG_TWEAK0, ph > 2 ? rand_word() : fill);
            write_reg(REG_TWEAK1, ph == 2 ? '1 : ph > 2 ? rand_word() : fill);
            // unmapped index must leave the key untouched
            write_reg(REG_SPARE, rand_word());
            write_reg(REG_UNUSED, rand_word());
            if (ph == NUM_PHASES) quiet <= 1'b1;
            for (int i = 0; i < 115; i++)
                put_block($urandom_range(0, 1), rand_word(), rand_word(),
                          rand_word(), rand_word());
        end
        settle();

        $display("Sent %0d blocks, checked %0d outputs over %0d key/tweak settings.",
                 blocks_sent, blocks_checked, NUM_PHASES + 1);
        $display("Covered encrypt and decrypt, extreme words and unmapped register writes.");
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

/* threefish256_block_cipher.f */
+incdir+src
src/tf256_pkg.sv
src/tf256_front.sv
src/tf256_round.sv
src/tf256_back.sv
src/threefish256_block_cipher.sv
bench/threefish256_checker.sv
bench/testbench.sv
